[rtl/r5rd_pkg.sv]
// ----------------------------------------------------------------------------
// r5rd_pkg
// Shared constants and types of the RAID-5 block read and rebuild engine.
// ----------------------------------------------------------------------------
`default_nettype none

package r5rd_pkg;

    localparam int MAX_DISKS   = 8;
    localparam int DISK_DEPTH  = 1024;
    localparam int DISK_W      = $clog2(MAX_DISKS);
    localparam int POS_W       = $clog2(DISK_DEPTH);
    localparam int STORE_DEPTH = MAX_DISKS * DISK_DEPTH;
    localparam int STORE_AW    = DISK_W + POS_W;
    localparam int WORD_W      = 32;
    localparam int CFG_W       = 11;
    localparam int NDISK_W     = 4;
    localparam int DIVISOR_W   = 14;
    localparam int STEP_W      = 6;

    localparam logic [STEP_W-1:0] STEPS_LAYER = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_IDX   = 6'd14;
    localparam logic [STEP_W-1:0] STEPS_ROT   = 6'd10;

    typedef enum logic [1:0] {
        CFG_NUM_DISKS       = 2'd0,
        CFG_STRIP_BLOCKS    = 2'd1,
        CFG_BLOCKS_PER_DISK = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_READ = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAYER,
        ST_IDX,
        ST_ROT,
        ST_MAP,
        ST_PROBE,
        ST_XOR,
        ST_DONE
    } rd_state_t;

    typedef struct packed {
        logic                 start;
        logic [WORD_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
        logic [STEP_W-1:0]    steps;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [WORD_W-1:0]    quot;
        logic [DIVISOR_W-1:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

[rtl/r5rd_ram.sv]
// ----------------------------------------------------------------------------
// r5rd_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module r5rd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/r5rd_div.sv]
// ----------------------------------------------------------------------------
// r5rd_div
// Shared restoring divider, one quotient bit per cycle. The dividend arrives
// left aligned; after the given number of steps the quotient sits in the low
// bits of quot and the remainder in rem.
// ----------------------------------------------------------------------------
`default_nettype none

module r5rd_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire r5rd_pkg::div_req_t  req,
    output r5rd_pkg::div_rsp_t       rsp
);

    import r5rd_pkg::*;

    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next = req.dividend;
            rem_next = '0;
            den_next = req.divisor;
            cnt_next = req.steps;
        end else if (cnt_reg != '0) begin
            quo_next  = {quo_reg[WORD_W-2:0], ge};
            rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = cnt_reg != '0;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

[rtl/raid5_block_read_reconstruct_unit.sv]
// ----------------------------------------------------------------------------
// raid5_block_read_reconstruct_unit
// RAID-5 read engine with rotating parity. Load items fill the disk store and
// mark disks present; read items map a logical block, return it directly or
// rebuild it by XOR over the other disks, or report it unavailable.
//
// Channel   Direction  Handshake          Contents
// s_        in         s_valid/s_ready    load word or logical block read
// m_        out        m_valid/m_ready    block data and available flag
// cfg_      in         cfg_wr_en          num_disks, strip_blocks, blocks_per_disk
//
// A load item is written as it is accepted. A read item holds the block through
// three divisions, the map and a store read, a rebuild or an unavailable
// answer; a layer quotient of at least the disk depth ends it after the first
// division. The shared divider runs 32 steps on the layer, 14 on the strip
// offset and 10 on the parity rotation, and a rebuild reads one disk per cycle
// from the single store read port. Reset sets two disks, a one-block strip and
// zero blocks per disk and clears the presence mask; the store is not cleared.
// A result waiting on m_ready leaves the block ready for the next item; the
// following result then waits in the final state until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module raid5_block_read_reconstruct_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [r5rd_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [r5rd_pkg::DISK_W-1:0]   s_disk_index,
    input  wire logic [r5rd_pkg::POS_W-1:0]    s_word_index,
    input  wire logic [r5rd_pkg::WORD_W-1:0]   s_word_data,
    input  wire logic [r5rd_pkg::WORD_W-1:0]   s_block_number,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [r5rd_pkg::WORD_W-1:0]        m_block_data,
    output logic                               m_available
);

    import r5rd_pkg::*;

    logic [NDISK_W-1:0]   num_disks_reg;
    logic [CFG_W-1:0]     strip_reg;
    logic [CFG_W-1:0]     bpd_reg;
    logic [MAX_DISKS-1:0] present_reg, present_next;

    rd_state_t            state_reg, state_next;
    logic [POS_W-1:0]     layer_reg, layer_next;
    logic [2:0]           sub_q_reg, sub_q_next;
    logic [CFG_W-1:0]     sub_r_reg, sub_r_next;
    logic [20:0]          prod_reg, prod_next;
    logic [DISK_W-1:0]    disk_reg, disk_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 in_range_reg, in_range_next;
    logic [NDISK_W-1:0]   j_reg, j_next;
    logic                 pend_reg, pend_next;
    logic [WORD_W-1:0]    acc_reg, acc_next;
    logic [WORD_W-1:0]    res_data_reg, res_data_next;
    logic                 res_avail_reg, res_avail_next;
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]    out_data_reg, out_data_next;
    logic                 out_avail_reg, out_avail_next;

    logic [NDISK_W-1:0]   eff_n;
    logic [CFG_W-1:0]     eff_strip;
    logic [CFG_W-1:0]     eff_bpd;
    logic [14:0]          width_full;
    logic [NDISK_W-1:0]   pcount;
    logic                 cnt_ok;
    logic [NDISK_W-1:0]   parity;
    logic [NDISK_W-1:0]   rot_sum;
    logic [21:0]          range_end;
    logic [20:0]          pos_sum;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 ram_we;
    logic [STORE_AW-1:0]  ram_waddr;
    logic                 ram_re;
    logic [STORE_AW-1:0]  ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic                 s_fire;

    r5rd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    r5rd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_word_data),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_disks_reg <= 4'd2;
            strip_reg     <= 11'd1;
            bpd_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_DISKS:       num_disks_reg <= cfg_wdata[NDISK_W-1:0];
                CFG_STRIP_BLOCKS:    strip_reg     <= cfg_wdata;
                CFG_BLOCKS_PER_DISK: bpd_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (num_disks_reg < 4'd2) begin
            eff_n = 4'd2;
        end else if (num_disks_reg > NDISK_W'(MAX_DISKS)) begin
            eff_n = NDISK_W'(MAX_DISKS);
        end else begin
            eff_n = num_disks_reg;
        end
        eff_strip  = (strip_reg == '0) ? 11'd1 : strip_reg;
        eff_bpd    = (bpd_reg > CFG_W'(DISK_DEPTH)) ? CFG_W'(DISK_DEPTH) : bpd_reg;
        width_full = 15'(eff_strip) * 15'(eff_n - 4'd1);
    end

    always_comb begin
        pcount = '0;
        for (int k = 0; k < MAX_DISKS; k++) begin
            if (present_reg[k] && (NDISK_W'(k) < eff_n)) begin
                pcount = pcount + 4'd1;
            end
        end
        cnt_ok = (pcount + 4'd1) >= eff_n;
    end

    assign parity    = eff_n - 4'd1 - {1'b0, div_rsp.rem[2:0]};
    assign rot_sum   = parity + 4'd1 + {1'b0, sub_q_reg};
    assign range_end = {1'b0, prod_reg} + 22'(eff_strip);
    assign pos_sum   = prod_reg + 21'(sub_r_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        present_next   = present_reg;
        layer_next     = layer_reg;
        sub_q_next     = sub_q_reg;
        sub_r_next     = sub_r_reg;
        prod_next      = prod_reg;
        disk_next      = disk_reg;
        pos_next       = pos_reg;
        in_range_next  = in_range_reg;
        j_next         = j_reg;
        pend_next      = 1'b0;
        acc_next       = acc_reg;
        res_data_next  = res_data_reg;
        res_avail_next = res_avail_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        out_avail_next = out_avail_reg;
        div_req        = '0;
        ram_we         = 1'b0;
        ram_waddr      = {s_disk_index, s_word_index};
        ram_re         = 1'b0;
        ram_raddr      = {disk_reg, pos_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_req_type == REQ_LOAD) begin
                        ram_we = 1'b1;
                        present_next[s_disk_index] = 1'b1;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = s_block_number;
                        div_req.divisor  = width_full[DIVISOR_W-1:0];
                        div_req.steps    = STEPS_LAYER;
                        state_next       = ST_LAYER;
                    end
                end
            end
            ST_LAYER: begin
                if (div_rsp.done) begin
                    layer_next = div_rsp.quot[POS_W-1:0];
                    if (div_rsp.quot[WORD_W-1:POS_W] != '0) begin
                        res_data_next  = '0;
                        res_avail_next = 1'b0;
                        state_next     = ST_DONE;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {div_rsp.rem, 18'd0};
                        div_req.divisor  = DIVISOR_W'(eff_strip);
                        div_req.steps    = STEPS_IDX;
                        state_next       = ST_IDX;
                    end
                end
            end
            ST_IDX: begin
                if (div_rsp.done) begin
                    sub_q_next       = div_rsp.quot[2:0];
                    sub_r_next       = div_rsp.rem[CFG_W-1:0];
                    prod_next        = 21'(layer_reg) * 21'(eff_strip);
                    div_req.start    = 1'b1;
                    div_req.dividend = {layer_reg, 22'd0};
                    div_req.divisor  = DIVISOR_W'(eff_n);
                    div_req.steps    = STEPS_ROT;
                    state_next       = ST_ROT;
                end
            end
            ST_ROT: begin
                if (div_rsp.done) begin
                    disk_next = (rot_sum >= eff_n) ? DISK_W'(rot_sum - eff_n)
                                                   : DISK_W'(rot_sum);
                    in_range_next = range_end <= 22'(eff_bpd);
                    pos_next      = pos_sum[POS_W-1:0];
                    state_next    = ST_MAP;
                end
            end
            ST_MAP: begin
                if (!in_range_reg) begin
                    res_data_next  = '0;
                    res_avail_next = 1'b0;
                    state_next     = ST_DONE;
                end else if (present_reg[disk_reg]) begin
                    ram_re     = 1'b1;
                    state_next = ST_PROBE;
                end else if (!cnt_ok) begin
                    res_data_next  = '0;
                    res_avail_next = 1'b0;
                    state_next     = ST_DONE;
                end else begin
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = ST_XOR;
                end
            end
            ST_PROBE: begin
                res_data_next  = ram_rdata;
                res_avail_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_XOR: begin
                ram_raddr = {j_reg[DISK_W-1:0], pos_reg};
                if (pend_reg) begin
                    acc_next = acc_reg ^ ram_rdata;
                end
                if (j_reg < eff_n) begin
                    ram_re    = 1'b1;
                    pend_next = (j_reg[DISK_W-1:0] != disk_reg);
                    j_next    = j_reg + 4'd1;
                end else begin
                    res_data_next  = acc_next;
                    res_avail_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_data_next  = res_data_reg;
                    out_avail_next = res_avail_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        layer_reg     <= layer_next;
        sub_q_reg     <= sub_q_next;
        sub_r_reg     <= sub_r_next;
        prod_reg      <= prod_next;
        disk_reg      <= disk_next;
        pos_reg       <= pos_next;
        in_range_reg  <= in_range_next;
        j_reg         <= j_next;
        acc_reg       <= acc_next;
        res_data_reg  <= res_data_next;
        res_avail_reg <= res_avail_next;
        out_data_reg  <= out_data_next;
        out_avail_reg <= out_avail_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_block_data = out_data_reg;
    assign m_available  = out_avail_reg;

    // A new result only follows the completion of a read item.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished read item");

    // An unavailable answer carries zero data.
    a_unavail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_available) |-> (m_block_data == '0))
        else $error("unavailable result with nonzero data");

    // The shared divider is never restarted while it is still stepping.
    a_div_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The rebuild disk counter never runs past the array width.
    a_xor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XOR) |-> (j_reg <= eff_n))
        else $error("rebuild counter out of range");

endmodule

`default_nettype wire
